@@ rtl/core/triangle_strip_assembler_top_macros.svh @@
// Assertion macros for the checker
`ifndef TRIANGLE_STRIP_ASSEMBLER_TOP_MACROS_SVH
`define TRIANGLE_STRIP_ASSEMBLER_TOP_MACROS_SVH

// Checked only while out of reset
`define TSA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define TSA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/tsa_pkg.sv @@
package tsa_pkg;

    localparam int VERTEX_BITS = 16;
    localparam int SUM_BITS    = 17;
    localparam int MAT_BITS    = 11;
    localparam int TEX_BITS    = 10;

    localparam logic [7:0] BYTE_ERROR   = 8'h80;
    localparam logic [7:0] RESTART_BIAS = 8'h81;
    localparam logic [1:0] HELD_DEPTH   = 2'd3;

    localparam logic [MAT_BITS-1:0] MAT_NONE  = 11'd0;
    localparam logic [MAT_BITS-1:0] MAT_DUMMY = 11'd1;
    localparam logic [MAT_BITS-1:0] MAT_BIAS  = 11'd2;

    typedef enum logic [1:0]
    {
        OP_INDEX  = 2'd0,
        OP_BEGIN  = 2'd1,
        OP_FINISH = 2'd2
    } op_t;

    typedef enum logic [1:0]
    {
        ERR_NONE   = 2'd0,
        ERR_BYTE   = 2'd1,
        ERR_RANGE  = 2'd2,
        ERR_SHORT  = 2'd3
    } err_t;

    typedef struct packed
    {
        logic [VERTEX_BITS-1:0] a;
        logic [VERTEX_BITS-1:0] b;
        logic [VERTEX_BITS-1:0] c;
    } face_t;

    // Every result one transaction produces
    typedef struct packed
    {
        face_t [2:0]         faces;
        logic [MAT_BITS-1:0] material;
        logic [1:0]          count;
        logic                marker;
        err_t                err;
    } bundle_t;

    function automatic logic [1:0] ring_next_pos(input logic [1:0] p);
        begin
            ring_next_pos = (p == 2'd2) ? 2'd0 : p + 2'd1;
        end
    endfunction

    function automatic logic [1:0] ring_prev_pos(input logic [1:0] p);
        begin
            ring_prev_pos = (p == 2'd0) ? 2'd2 : p - 2'd1;
        end
    endfunction

endpackage

@@ rtl/core/triangle_strip_assembler_top.sv @@
// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_stall     operation, index_byte, side_index,
//                                              texture_number, base_vertex, vertex_total
// output    out        out_valid / out_stall   corner_a..c, material_id, item_kind,
//                                              error_code, last_flag
// config    in         cfg_wr_en               cfg_wr_data (texture limit)
//
// One input transaction per cycle while in_stall is low; the strip ring, held faces and group state
// update in the cycle the transaction is accepted.
// Results leave one per cycle while out_stall is low; a transaction with three results holds the output
// until all three have left, so the input then runs at the result rate.
// A two-entry result buffer lets input continue while out_stall is high, then
// in_stall rises. Reset is asynchronous and clears all control state.
module triangle_strip_assembler_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [tsa_pkg::TEX_BITS-1:0]   cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     operation,
    input  logic [7:0]                     index_byte,
    input  logic [7:0]                     side_index,
    input  logic signed [10:0]             texture_number,
    input  logic [15:0]                    base_vertex,
    input  logic [15:0]                    vertex_total,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [15:0]                    corner_a,
    output logic [15:0]                    corner_b,
    output logic [15:0]                    corner_c,
    output logic [10:0]                    material_id,
    output logic                           item_kind,
    output logic [1:0]                     error_code,
    output logic                           last_flag
);
    import tsa_pkg::*;

    logic [TEX_BITS-1:0]               texture_limit_reg;
    logic [2:0][VERTEX_BITS-1:0]       ring_reg, ring_next;
    logic [1:0]                        pos_reg, pos_next;
    logic                              rev_reg, rev_next;
    face_t [2:0]                       held_reg, held_next;
    logic [1:0]                        hcnt_reg, hcnt_next;
    logic [MAT_BITS-1:0]               mat_reg, mat_next;
    logic                              stopped_reg, stopped_next;
    logic [15:0]                       base_reg, base_next;
    logic [15:0]                       limit_reg, limit_next;

    bundle_t                           head_reg, tail_reg, new_bundle;
    logic                              head_valid_reg, tail_valid_reg, new_valid;
    logic [1:0]                        idx_reg;

    logic                              accept;
    logic [7:0]                        offset;
    logic [SUM_BITS-1:0]               vsum;
    logic [VERTEX_BITS-1:0]            vtx;
    logic                              in_range;
    logic [MAT_BITS-1:0]               tex_mat;
    face_t                             new_face;
    face_t                             out_face;
    logic                              pop, last_res, head_free;

    assign in_stall = tail_valid_reg;
    assign accept   = in_valid & ~in_stall;

    always_comb
    begin
        if (index_byte == 8'd0)
        begin
            offset = side_index - 8'd1;
        end
        else if (index_byte[7])
        begin
            offset = index_byte - RESTART_BIAS;
        end
        else
        begin
            offset = index_byte - 8'd1;
        end
    end

    assign vsum     = {1'b0, base_reg} + {{(SUM_BITS-8){1'b0}}, offset};
    assign vtx      = VERTEX_BITS'(vsum);
    assign in_range = vsum < {1'b0, limit_reg};

    always_comb
    begin
        if (texture_number[10])
        begin
            tex_mat = MAT_NONE;
        end
        else if (texture_number[TEX_BITS-1:0] >= texture_limit_reg)
        begin
            tex_mat = MAT_DUMMY;
        end
        else
        begin
            tex_mat = {1'b0, texture_number[TEX_BITS-1:0]} + MAT_BIAS;
        end
    end

    always_comb
    begin
        if (rev_reg)
        begin
            new_face.a = vtx;
            new_face.b = ring_reg[ring_prev_pos(pos_reg)];
            new_face.c = ring_reg[ring_next_pos(pos_reg)];
        end
        else
        begin
            new_face.a = ring_reg[ring_next_pos(pos_reg)];
            new_face.b = ring_reg[ring_prev_pos(pos_reg)];
            new_face.c = vtx;
        end
    end

    always_comb
    begin
        ring_next    = ring_reg;
        pos_next     = pos_reg;
        rev_next     = rev_reg;
        held_next    = held_reg;
        hcnt_next    = hcnt_reg;
        mat_next     = mat_reg;
        stopped_next = stopped_reg;
        base_next    = base_reg;
        limit_next   = limit_reg;
        new_bundle   = '0;
        new_valid    = 1'b0;
        if (accept)
        begin
            case (op_t'(operation))
                OP_BEGIN:
                begin
                    base_next    = base_vertex;
                    limit_next   = vertex_total;
                    ring_next    = '0;
                    pos_next     = 2'd0;
                    rev_next     = 1'b1;
                    stopped_next = 1'b0;
                end
                OP_FINISH:
                begin
                    new_valid = 1'b1;
                    if (hcnt_reg != 2'd0)
                    begin
                        new_bundle.faces    = held_reg;
                        new_bundle.count    = hcnt_reg;
                        new_bundle.material = mat_reg;
                    end
                    else
                    begin
                        new_bundle.count  = 2'd1;
                        new_bundle.marker = 1'b1;
                    end
                    ring_next    = '0;
                    pos_next     = 2'd0;
                    rev_next     = 1'b1;
                    hcnt_next    = 2'd0;
                    mat_next     = MAT_NONE;
                    stopped_next = 1'b0;
                    base_next    = '0;
                    limit_next   = '0;
                end
                OP_INDEX:
                begin
                    if (!stopped_reg)
                    begin
                        if (index_byte == BYTE_ERROR)
                        begin
                            new_valid        = 1'b1;
                            new_bundle.count = 2'd1;
                            new_bundle.marker = 1'b1;
                            new_bundle.err   = ERR_BYTE;
                            stopped_next     = 1'b1;
                        end
                        else if (index_byte == 8'd0 && side_index == 8'd0)
                        begin
                            new_valid         = 1'b1;
                            new_bundle.count  = 2'd1;
                            new_bundle.marker = 1'b1;
                            stopped_next      = 1'b1;
                            if (hcnt_reg < HELD_DEPTH)
                            begin
                                new_bundle.err = ERR_SHORT;
                            end
                            else
                            begin
                                hcnt_next = 2'd0;
                            end
                        end
                        else if (!in_range)
                        begin
                            new_valid         = 1'b1;
                            new_bundle.count  = 2'd1;
                            new_bundle.marker = 1'b1;
                            new_bundle.err    = ERR_RANGE;
                            stopped_next      = 1'b1;
                        end
                        else
                        begin
                            ring_next[pos_reg] = vtx;
                            pos_next           = ring_next_pos(pos_reg);
                            rev_next           = ~rev_reg;
                            if (index_byte == 8'd0)
                            begin
                                // new material group: flush what is held
                                new_valid           = hcnt_reg != 2'd0;
                                new_bundle.faces    = held_reg;
                                new_bundle.count    = hcnt_reg;
                                new_bundle.material = mat_reg;
                                hcnt_next           = 2'd0;
                                mat_next            = tex_mat;
                            end
                            else if (!index_byte[7])
                            begin
                                if (hcnt_reg == HELD_DEPTH)
                                begin
                                    new_valid           = 1'b1;
                                    new_bundle.faces[0] = held_reg[0];
                                    new_bundle.count    = 2'd1;
                                    new_bundle.material = mat_reg;
                                    held_next[0]        = held_reg[1];
                                    held_next[1]        = held_reg[2];
                                    held_next[2]        = new_face;
                                end
                                else
                                begin
                                    held_next[hcnt_reg] = new_face;
                                    hcnt_next           = hcnt_reg + 2'd1;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            texture_limit_reg <= '0;
            ring_reg          <= '0;
            pos_reg           <= 2'd0;
            rev_reg           <= 1'b1;
            hcnt_reg          <= 2'd0;
            mat_reg           <= MAT_NONE;
            stopped_reg       <= 1'b0;
            base_reg          <= '0;
            limit_reg         <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                texture_limit_reg <= cfg_wr_data;
            end
            ring_reg    <= ring_next;
            pos_reg     <= pos_next;
            rev_reg     <= rev_next;
            hcnt_reg    <= hcnt_next;
            mat_reg     <= mat_next;
            stopped_reg <= stopped_next;
            base_reg    <= base_next;
            limit_reg   <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    // result buffer: head drains one result per cycle while out_stall is low, tail catches one transaction
    assign pop       = head_valid_reg & ~out_stall;
    assign last_res  = idx_reg == (head_reg.count - 2'd1);
    assign head_free = ~head_valid_reg | (pop & last_res);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
            idx_reg        <= 2'd0;
        end
        else
        begin
            if (pop)
            begin
                idx_reg <= last_res ? 2'd0 : idx_reg + 2'd1;
            end
            if (head_free)
            begin
                if (tail_valid_reg)
                begin
                    tail_valid_reg <= 1'b0;
                end
                else
                begin
                    head_valid_reg <= new_valid;
                end
            end
            else if (new_valid)
            begin
                tail_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_free)
        begin
            head_reg <= tail_valid_reg ? tail_reg : new_bundle;
        end
        if (new_valid && !head_free)
        begin
            tail_reg <= new_bundle;
        end
    end

    assign out_face    = head_reg.faces[idx_reg];
    assign out_valid   = head_valid_reg;
    assign corner_a    = 16'(out_face.a);
    assign corner_b    = 16'(out_face.b);
    assign corner_c    = 16'(out_face.c);
    assign material_id = head_reg.material;
    assign item_kind   = head_reg.marker;
    assign error_code  = head_reg.err;
    assign last_flag   = last_res;

endmodule

@@ rtl/core/tsa_checker.sv @@
`include "triangle_strip_assembler_top_macros.svh"

module tsa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] corner_a,
    input logic [15:0] corner_b,
    input logic [15:0] corner_c,
    input logic [10:0] material_id,
    input logic        item_kind,
    input logic        last_flag
);
    import tsa_pkg::*;

    logic marker_clear;

    assign marker_clear = last_flag && corner_a == 16'd0 && corner_b == 16'd0
                          && corner_c == 16'd0 && material_id == MAT_NONE;

    `TSA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")

    // a transaction's results leave back to back until the last one
    `TSA_ASSERT(a_burst_cont, out_valid && !out_stall && !last_flag |=> out_valid, "result burst broken")

    `TSA_ASSERT(a_marker_form, out_valid && item_kind |-> marker_clear, "malformed marker")

    `TSA_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "output valid during reset")

endmodule

bind triangle_strip_assembler_top tsa_checker u_tsa_checker (.*);

@@ dv/tb_strip_pkg.sv @@
`timescale 1ns / 100ps

package tb_strip_pkg;

    import tsa_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed
    {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [10:0] material;
        logic        marker;
        logic [1:0]  err;
        logic        last;
    } strip_result_t;

    class strip_scoreboard;

        logic [9:0]    texture_cap;
        logic [15:0]   ring [3];
        int            ring_pos;
        bit            reverse;
        face_t         held [3];
        int            held_n;
        logic [10:0]   material;
        bit            stopped;
        logic [15:0]   sub_base;
        logic [15:0]   sub_limit;
        strip_result_t faces_due [$];
        int            errors;

        function new();
            texture_cap = '0;
            errors = 0;
            clear_strip();
        endfunction

        function void clear_strip();
            ring = '{default: '0};
            ring_pos = 0;
            reverse = 1'b1;
            held_n = 0;
            material = MAT_NONE;
            stopped = 1'b0;
            sub_base = '0;
            sub_limit = '0;
        endfunction

        function void set_limit(logic [9:0] v);
            texture_cap = v;
        endfunction

        function int pending();
            return faces_due.size();
        endfunction

        function void emit(face_t f, logic [10:0] m, logic mk, err_t e);
            strip_result_t r;
            r.a = f.a;
            r.b = f.b;
            r.c = f.c;
            r.material = m;
            r.marker = mk;
            r.err = e;
            r.last = 1'b0;
            faces_due.insert(faces_due.size(), r);
        endfunction

        function void halt(err_t e);
            emit('0, MAT_NONE, 1'b1, e);
            stopped = 1'b1;
        endfunction

        function void flush_held();
            for (int i = 0; i < held_n; i++)
                emit(held[i], material, 1'b0, ERR_NONE);
            held_n = 0;
        endfunction

        function logic [10:0] group_material(logic [10:0] tn);
            if (tn[10])
                return MAT_NONE;
            else if (tn[9:0] >= texture_cap)
                return MAT_DUMMY;
            return MAT_BIAS + tn;
        endfunction

        function void push_vertex(int unsigned v, bit with_face);
            face_t f;
            int p;
            p = ring_pos;
            ring[p] = v[15:0];
            if (with_face)
            begin
                if (reverse)
                begin
                    f.a = ring[p];
                    f.b = ring[(p + 2) % 3];
                    f.c = ring[(p + 1) % 3];
                end
                else
                begin
                    f.a = ring[(p + 1) % 3];
                    f.b = ring[(p + 2) % 3];
                    f.c = ring[p];
                end
                if (held_n >= HELD_DEPTH)
                begin
                    emit(held[0], material, 1'b0, ERR_NONE);
                    held[0] = held[1];
                    held[1] = held[2];
                    held_n = 2;
                end
                held[held_n] = f;
                held_n++;
            end
            ring_pos = (p + 1) % 3;
            reverse = !reverse;
        endfunction

        function void take_transaction(logic [1:0] op, logic [7:0] ib, logic [7:0] si,
                                       logic [10:0] tn, logic [15:0] bv, logic [15:0] vt);
            int first;
            int unsigned v;
            first = faces_due.size();
            case (op)
                OP_BEGIN:
                begin
                    sub_base = bv;
                    sub_limit = vt;
                    ring = '{default: '0};
                    ring_pos = 0;
                    reverse = 1'b1;
                    stopped = 1'b0;
                end
                OP_FINISH:
                begin
                    flush_held();
                    if (faces_due.size() == first)
                        emit('0, MAT_NONE, 1'b1, ERR_NONE);
                    clear_strip();
                end
                OP_INDEX:
                begin
                    if (!stopped)
                    begin
                        if (ib == BYTE_ERROR)
                            halt(ERR_BYTE);
                        else if (ib == 8'd0)
                        begin
                            if (si == 8'd0)
                            begin
                                if (held_n < HELD_DEPTH)
                                    halt(ERR_SHORT);
                                else
                                begin
                                    held_n = 0;
                                    emit('0, MAT_NONE, 1'b1, ERR_NONE);
                                    stopped = 1'b1;
                                end
                            end
                            else
                            begin
                                v = int'(sub_base) + int'(si) - 1;
                                if (v >= sub_limit)
                                    halt(ERR_RANGE);
                                else
                                begin
                                    flush_held();
                                    material = group_material(tn);
                                    push_vertex(v, 1'b0);
                                end
                            end
                        end
                        else if (ib < BYTE_ERROR)
                        begin
                            v = int'(sub_base) + int'(ib) - 1;
                            if (v >= sub_limit)
                                halt(ERR_RANGE);
                            else
                                push_vertex(v, 1'b1);
                        end
                        else
                        begin
                            v = int'(sub_base) + int'(ib) - int'(RESTART_BIAS);
                            if (v >= sub_limit)
                                halt(ERR_RANGE);
                            else
                                push_vertex(v, 1'b0);
                        end
                    end
                end
                default: ;
            endcase
            if (faces_due.size() > first)
                faces_due[faces_due.size() - 1].last = 1'b1;
        endfunction

        function void match_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(strip_result_t got);
            strip_result_t want;
            if (faces_due.size() == 0)
            begin
                $error("unexpected result: corners %0d %0d %0d, item_kind %0d, error_code %0d",
                       got.a, got.b, got.c, got.marker, got.err);
                errors++;
                return;
            end
            want = faces_due.pop_front();
            match_field("corner_a", want.a, got.a);
            match_field("corner_b", want.b, got.b);
            match_field("corner_c", want.c, got.c);
            match_field("material_id", want.material, got.material);
            match_field("item_kind", want.marker, got.marker);
            match_field("error_code", want.err, got.err);
            match_field("last_flag", want.last, got.last);
        endfunction

    endclass

endpackage

@@ dv/tb_triangle_strip_assembler_top.sv @@
`timescale 1ns / 100ps

module tb_triangle_strip_assembler_top;

    import tsa_pkg::*;
    import tb_strip_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [9:0]  cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = OP_INDEX;
    logic [7:0]  index_byte = '0;
    logic [7:0]  side_index = '0;
    logic [10:0] texture_number = '0;
    logic [15:0] base_vertex = '0;
    logic [15:0] vertex_total = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] corner_a;
    logic [15:0] corner_b;
    logic [15:0] corner_c;
    logic [10:0] material_id;
    logic        item_kind;
    logic [1:0]  error_code;
    logic        last_flag;

    strip_scoreboard sb;
    int send_gap_pct = 0;
    int hold_pct = 0;
    int offered = 0;

    triangle_strip_assembler_top DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .index_byte     (index_byte),
        .side_index     (side_index),
        .texture_number (texture_number),
        .base_vertex    (base_vertex),
        .vertex_total   (vertex_total),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .corner_a       (corner_a),
        .corner_b       (corner_b),
        .corner_c       (corner_c),
        .material_id    (material_id),
        .item_kind      (item_kind),
        .error_code     (error_code),
        .last_flag      (last_flag)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < hold_pct);

    // input transaction first, in case a result leaves in the same cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.take_transaction(operation, index_byte, side_index, texture_number,
                                    base_vertex, vertex_total);
            if (out_valid && !out_stall)
                sb.check_result(strip_result_t'{corner_a, corner_b, corner_c, material_id,
                                                item_kind, error_code, last_flag});
        end
    end

    task automatic offer(logic [1:0] op, logic [7:0] ib, logic [7:0] si, logic [10:0] tn,
                         logic [15:0] bv, logic [15:0] vt);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        operation <= op;
        index_byte <= ib;
        side_index <= si;
        texture_number <= tn;
        base_vertex <= bv;
        vertex_total <= vt;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op != OP_UNUSED)
            offered++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(logic [9:0] v);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        sb.set_limit(v);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [10:0] pick_tex();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20)
            return 11'h7FF;
        else if (r < 30)
            return {1'b1, 10'($urandom)};
        else if (r < 65)
            return 11'($urandom_range(0, 63));
        return 11'($urandom_range(0, 1023));
    endfunction

    function automatic logic [7:0] face_byte(int unsigned span);
        int unsigned hi;
        hi = (span < 1) ? 1 : ((span > 127) ? 127 : span);
        return 8'($urandom_range(1, hi));
    endfunction

    function automatic logic [7:0] restart_byte(int unsigned span);
        int unsigned hi;
        hi = (span < 1) ? 0 : ((span > 127) ? 126 : span - 1);
        return RESTART_BIAS + 8'($urandom_range(0, hi));
    endfunction

    task automatic group_start(int unsigned span);
        int unsigned hi;
        hi = (span < 1) ? 1 : ((span > 255) ? 255 : span);
        offer(OP_INDEX, 8'd0, 8'($urandom_range(1, hi)), pick_tex(), 16'($urandom),
              16'($urandom));
    endtask

    task automatic strip_run();
        int unsigned base;
        int unsigned total;
        int unsigned span;
        int unsigned r;
        case ($urandom_range(3))
            0: base = 0;
            1: base = $urandom_range(0, 300);
            2: base = $urandom_range(0, 65535);
            default: base = 65535 - $urandom_range(0, 300);
        endcase
        total = base + $urandom_range(1, 160);
        if (total > 65535)
            total = 65535;
        span = total - base;
        offer(OP_BEGIN, 8'($urandom), 8'($urandom), 11'($urandom), base[15:0], total[15:0]);
        group_start(span);
        repeat ($urandom_range(2, 14))
        begin
            r = $urandom_range(99);
            if (r < 74)
                offer(OP_INDEX, face_byte(span), 8'($urandom), 11'($urandom),
                      16'($urandom), 16'($urandom));
            else if (r < 86)
                offer(OP_INDEX, restart_byte(span), 8'($urandom), 11'($urandom),
                      16'($urandom), 16'($urandom));
            else if (r < 93)
                group_start(span);
            else if (r < 97)
                offer(OP_INDEX, 8'($urandom), 8'($urandom), pick_tex(),
                      16'($urandom), 16'($urandom));
            else
                offer(OP_INDEX, 8'd0, 8'd0, 11'($urandom), 16'($urandom), 16'($urandom));
        end
        r = $urandom_range(99);
        if (r < 65)
            offer(OP_INDEX, 8'd0, 8'd0, 11'($urandom), 16'($urandom), 16'($urandom));
        if (r >= 65 && r < 85 || r < 20)
            offer(OP_FINISH, 8'($urandom), 8'($urandom), 11'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 3))
            offer(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 11'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    task automatic random_phase(int gap, int hold, int count, bit pause_midway);
        int goal;
        bit paused;
        send_gap_pct = gap;
        hold_pct = hold;
        goal = offered + count;
        paused = 1'b0;
        while (offered < goal)
        begin
            if (pause_midway && !paused && offered >= goal - count / 2)
            begin
                settle();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 85)
                strip_run();
            else
                noise_burst();
        end
    endtask

    task automatic directed_part();
        offer(OP_FINISH, 8'd0, 8'd0, 11'd0, 16'd0, 16'd0);
        offer(OP_BEGIN, 8'd0, 8'd0, 11'd0, 16'd0, 16'hFFFF);
        offer(OP_INDEX, BYTE_ERROR, 8'd0, 11'd0, 16'd0, 16'd0);
        offer(OP_INDEX, 8'd5, 8'd0, 11'd0, 16'd0, 16'd0);
        offer(OP_BEGIN, 8'd0, 8'd0, 11'd0, 16'hFFFF, 16'hFFFF);
        offer(OP_INDEX, 8'd1, 8'd0, 11'd0, 16'd0, 16'd0);
        offer(OP_BEGIN, 8'd0, 8'd0, 11'd0, 16'd100, 16'hFFFF);
        offer(OP_INDEX, 8'd0, 8'd255, 11'h7FF, 16'd0, 16'd0);
        offer(OP_INDEX, 8'd1, 8'd0, 11'd0, 16'd0, 16'd0);
        offer(OP_INDEX, 8'd127, 8'd0, 11'd0, 16'd0, 16'd0);
        offer(OP_INDEX, RESTART_BIAS, 8'd0, 11'd0, 16'd0, 16'd0);
        offer(OP_INDEX, 8'hFF, 8'd0, 11'd0, 16'd0, 16'd0);
        offer(OP_INDEX, 8'd2, 8'd0, 11'd0, 16'd0, 16'd0);
        offer(OP_INDEX, 8'd3, 8'd0, 11'd0, 16'd0, 16'd0);
        offer(OP_INDEX, 8'd4, 8'd0, 11'd0, 16'd0, 16'd0);
        offer(OP_INDEX, 8'd0, 8'd1, 11'd1023, 16'd0, 16'd0);
        offer(OP_INDEX, 8'd0, 8'd0, 11'd0, 16'd0, 16'd0);
        offer(OP_BEGIN, 8'd0, 8'd0, 11'd0, 16'd0, 16'd10);
        for (int b = 1; b <= 4; b++)
            offer(OP_INDEX, 8'(b), 8'd0, 11'd0, 16'd0, 16'd0);
        offer(OP_INDEX, 8'd0, 8'd0, 11'd0, 16'd0, 16'd0);
        offer(OP_UNUSED, 8'd9, 8'd0, 11'd0, 16'd0, 16'd0);
        offer(OP_FINISH, 8'd0, 8'd0, 11'd0, 16'd0, 16'd0);
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_part();
        write_limit(10'd1023);
        random_phase(6, 76, 75, 1'b1);
        write_limit(10'd0);
        random_phase(76, 6, 75, 1'b0);
        write_limit(10'($urandom_range(1, 40)));
        random_phase(0, 0, 75, 1'b0);
        settle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
